// ===== hdl/bdfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bdfa_pkg: shared types and codes of the binary DFA word checker
// Holds the table entry layout, the status codes and the item opcodes.
// ----------------------------------------------------------------------------
package bdfa_pkg;

    // Width of a state index as carried in items and in the table.
    localparam int STATE_W = 4;

    // Width of an entry status code.
    localparam int STATUS_W = 2;

    // Width of the check word on the item port.
    localparam int WORD_PORT_W = 32;

    // Entry status codes; the unused fourth code behaves as intermediate.
    localparam logic [STATUS_W-1:0] STATUS_INTER = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FINAL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DEAD  = 2'd2;

    // Item opcodes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    // One table entry.
    typedef struct packed {
        logic [STATE_W-1:0]  next_zero;
        logic [STATE_W-1:0]  next_one;
        logic [STATUS_W-1:0] status;
    } entry_t;

    // Status of the walker toward the top level.
    typedef struct packed {
        logic busy;
        logic done;
        logic accepted;
    } walk_status_t;

endpackage

// ===== hdl/bdfa_table.sv =====
// ----------------------------------------------------------------------------
// bdfa_table: transition table of the automaton
// Register array with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bdfa_table #(
    parameter int IDX_W = 4
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_idx,
    input  bdfa_pkg::entry_t     wr_entry,
    input  logic [IDX_W-1:0]     rd_idx,
    output bdfa_pkg::entry_t     rd_entry
);
    import bdfa_pkg::*;

    localparam int DEPTH = 1 << IDX_W;

    entry_t table_reg [DEPTH];
    entry_t rd_entry_reg;

    // Entry write; contents are undefined until written.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_reg[wr_idx] <= wr_entry;
        end
    end

    // Entry read; the address is the state the walker moves to at this edge.
    always_ff @(posedge clk)
    begin
        rd_entry_reg <= table_reg[rd_idx];
    end

    assign rd_entry = rd_entry_reg;

endmodule

// ===== hdl/bdfa_walker.sv =====
// ----------------------------------------------------------------------------
// bdfa_walker: bit-serial walk of a word through the automaton
// Shifts the word out one bit per cycle and takes one transition per bit.
// ----------------------------------------------------------------------------
module bdfa_walker #(
    parameter int STATE_COUNT = 16,
    parameter int WORD_W      = 32,
    parameter int IDX_W       = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [WORD_W-1:0]                   word_in,
    input  logic [bdfa_pkg::STATE_W-1:0]        start_state,
    input  logic                                out_free,
    output logic [IDX_W-1:0]                    rd_idx,
    input  bdfa_pkg::entry_t                    rd_entry,
    output bdfa_pkg::walk_status_t              status
);
    import bdfa_pkg::*;

    typedef enum logic [1:0] {
        W_IDLE = 2'b01,
        W_WALK = 2'b10
    } walk_state_t;

    walk_state_t          state_reg, state_next;
    logic [WORD_W-1:0]    word_reg, word_next;
    logic [STATE_W-1:0]   cur_reg, cur_next;
    logic                 first_reg, first_next;

    logic                 in_range;
    logic [STATUS_W-1:0]  st_eff;
    logic                 stop;
    logic                 finish;

    // The next state addresses the table, so its entry is ready on arrival.
    assign rd_idx   = cur_next[IDX_W-1:0];
    assign in_range = int'(cur_reg) < STATE_COUNT;

    // Status of the current state; the start counts as intermediate.
    always_comb
    begin
        if (first_reg)
        begin
            st_eff = STATUS_INTER;
        end
        else if (!in_range)
        begin
            st_eff = STATUS_DEAD;
        end
        else
        begin
            st_eff = rd_entry.status;
        end
    end

    // The walk ends on an exhausted word, a dead state or an invalid state.
    assign stop   = (word_reg == '0) || (st_eff == STATUS_DEAD) || !in_range;
    assign finish = (state_reg == W_WALK) && stop && out_free;

    // Next-state logic of the walk.
    always_comb
    begin
        state_next = state_reg;
        word_next  = word_reg;
        cur_next   = cur_reg;
        first_next = first_reg;
        case (state_reg)
            W_IDLE:
            begin
                if (start)
                begin
                    state_next = W_WALK;
                    word_next  = word_in;
                    cur_next   = start_state;
                    first_next = 1'b1;
                end
            end
            W_WALK:
            begin
                if (stop)
                begin
                    if (out_free)
                    begin
                        state_next = W_IDLE;
                    end
                end
                else
                begin
                    cur_next   = word_reg[0] ? rd_entry.next_one : rd_entry.next_zero;
                    word_next  = word_reg >> 1;
                    first_next = 1'b0;
                end
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Shift register and walk registers.
    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        cur_reg   <= cur_next;
        first_reg <= first_next;
    end

    assign status.busy     = (state_reg != W_IDLE);
    assign status.done     = finish;
    assign status.accepted = (st_eff == STATUS_FINAL);

endmodule

// ===== hdl/binary_dfa_word_checker_core.sv =====
// ----------------------------------------------------------------------------
// binary_dfa_word_checker_core: programmable binary DFA word checker
// Write items load table entries; check items walk a word through the table
// and give one accepted flag.
// ----------------------------------------------------------------------------
// A write item writes its entry when taken. A check item walks the word through
// the walker one transition per bit, lowest bit first, up to the highest set bit
// (at most the word width), or fewer on a dead state; the result is registered.
// Throughput: one item at a time; one bit per cycle, then a wait for a free output.
// Reset: rst_n clears the control state and the start state register; the
// table is undefined until written.
module binary_dfa_word_checker_core #(
    parameter int STATE_COUNT = 16,
    parameter int WORD_BITS   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // Item input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [3:0]  entry_index,
    input  logic [3:0]  next_zero,
    input  logic [3:0]  next_one,
    input  logic [1:0]  entry_status,
    input  logic [31:0] word,
    // Result output
    output logic        out_valid,
    input  logic        out_stall,
    output logic        accepted,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bdfa_pkg::*;

    localparam int TABLE_STATES = (STATE_COUNT < (1 << STATE_W)) ? STATE_COUNT
                                                                 : (1 << STATE_W);
    localparam int IDX_W  = $clog2(TABLE_STATES);
    localparam int WORD_W = (WORD_BITS < WORD_PORT_W) ? WORD_BITS : WORD_PORT_W;

    logic [STATE_W-1:0] start_state_reg;
    logic               out_valid_reg;
    logic               accepted_reg;

    logic               in_take;
    logic               cfg_write;
    logic               tbl_wr_en;
    entry_t             wr_entry;
    entry_t             rd_entry;
    logic [IDX_W-1:0]   rd_idx;
    logic               out_free;
    walk_status_t       walk_status;

    // Item handshake: one item at a time.
    assign in_stall = walk_status.busy;
    assign in_take  = in_valid && !in_stall;

    // Table writes out of range are dropped.
    assign tbl_wr_en          = in_take && (op == OP_WRITE)
                                && (int'(entry_index) < STATE_COUNT);
    assign wr_entry.next_zero = next_zero;
    assign wr_entry.next_one  = next_one;
    assign wr_entry.status    = entry_status;

    bdfa_table #(
        .IDX_W (IDX_W)
    ) u_table (
        .clk      (clk),
        .wr_en    (tbl_wr_en),
        .wr_idx   (entry_index[IDX_W-1:0]),
        .wr_entry (wr_entry),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry)
    );

    bdfa_walker #(
        .STATE_COUNT (STATE_COUNT),
        .WORD_W      (WORD_W),
        .IDX_W       (IDX_W)
    ) u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (in_take && (op == OP_CHECK)),
        .word_in     (word[WORD_W-1:0]),
        .start_state (start_state_reg),
        .out_free    (out_free),
        .rd_idx      (rd_idx),
        .rd_entry    (rd_entry),
        .status      (walk_status)
    );

    // Output register frees as soon as its item is taken.
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (walk_status.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (walk_status.done)
        begin
            accepted_reg <= walk_status.accepted;
        end
    end

    assign out_valid = out_valid_reg;
    assign accepted  = accepted_reg;

    // Configuration register: the start state, decoded at byte addresses zero to three.
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_state_reg <= '0;
        end
        else if (cfg_write)
        begin
            start_state_reg <= pwdata[STATE_W-1:0];
        end
    end

    // Register read back.
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == 1'b0)
        begin
            prdata[STATE_W-1:0] = start_state_reg;
        end
    end

endmodule
